// ----- rtl/spq_pkg.sv -----
// Shared types and codes for the sorted-array priority queue.
// No dependencies; imported by spq_cell and sorted_array_priority_queue.
`default_nettype none

package spq_pkg;

  localparam int TAG_W     = 32;
  localparam int PRIO_W    = 16;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 8;
  localparam int DEPTH_DEF = 128;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_PEEK   = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // One stored entry as it moves between neighboring cells.
  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Operation broadcast to every cell in the row.
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/spq_cell.sv -----
// One slot of the sorted row: holds an entry and trades it with its neighbors.
// Depends on spq_pkg for entry_t and cell_ctl_t.
`default_nettype none

module spq_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire spq_pkg::cell_ctl_t ctl,
  input  wire spq_pkg::entry_t    new_entry,
  input  wire logic               take_left,
  input  wire spq_pkg::entry_t    left_entry,
  input  wire spq_pkg::entry_t    right_entry,
  output spq_pkg::entry_t         cur_entry,
  output logic                    take
);
  import spq_pkg::*;

  logic              valid_r, valid_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;

  assign cur_entry = '{valid: valid_r, tag: tag_r, prio: prio_r};

  // An empty slot ranks behind everything; ties stay ahead of the new entry.
  assign take = !valid_r || (new_entry.prio < prio_r);

  always_comb begin
    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    prio_nxt  = prio_r;
    if (ctl.ins && take) begin
      if (take_left) begin
        valid_nxt = left_entry.valid;
        tag_nxt   = left_entry.tag;
        prio_nxt  = left_entry.prio;
      end else begin
        valid_nxt = new_entry.valid;
        tag_nxt   = new_entry.tag;
        prio_nxt  = new_entry.prio;
      end
    end else if (ctl.rem) begin
      valid_nxt = right_entry.valid;
      tag_nxt   = right_entry.tag;
      prio_nxt  = right_entry.prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r  <= tag_nxt;
    prio_r <= prio_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/sorted_array_priority_queue.sv -----
// Sorted-array min priority queue built as a row of DEPTH shifting cells.
// The result is captured in the output register by the clock edge that accepts the transaction.
// Throughput: one transaction per cycle while in_stall is low; every cell updates in parallel each cycle.
// Reset clears the count and every cell's valid bit.
// Depends on spq_pkg and spq_cell.
`default_nettype none

module sorted_array_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [spq_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [spq_pkg::TAG_W-1:0]    in_tag,
  input  wire logic [spq_pkg::PRIO_W-1:0]   in_prio,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [spq_pkg::TAG_W-1:0]         out_head_tag,
  output logic [spq_pkg::PRIO_W-1:0]        out_head_prio,
  output logic [spq_pkg::STATUS_W-1:0]      out_status,
  output logic [spq_pkg::OCC_W-1:0]         out_occupancy
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t    cell_entry [DEPTH];
  logic      cell_take  [DEPTH];
  cell_ctl_t ctl;
  entry_t    new_entry;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             accept, full, empty;
  kind_t            kind;

  logic              out_valid_r;
  logic [TAG_W-1:0]  head_tag_r, head_tag_nxt;
  logic [PRIO_W-1:0] head_prio_r, head_prio_nxt;
  status_t           status_r, status_nxt;
  logic [OCC_W-1:0]  occ_r;
  logic [CNT_W+OCC_W-1:0] occ_ext;

  assign kind      = kind_t'(in_kind);
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = !cell_entry[0].valid;
  assign new_entry = '{valid: 1'b1, tag: in_tag, prio: in_prio};

  assign ctl.ins = accept && (kind == KIND_INSERT) && !full;
  assign ctl.rem = accept && (kind == KIND_REMOVE) && !empty;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic   take_left;
      entry_t left_entry;
      entry_t right_entry;
      if (gi == 0) begin : g_first
        assign take_left  = 1'b0;
        assign left_entry = '0;
      end else begin : g_mid
        assign take_left  = cell_take[gi-1];
        assign left_entry = cell_entry[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_entry = '0;
      end else begin : g_notlast
        assign right_entry = cell_entry[gi+1];
      end
      spq_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .new_entry   (new_entry),
        .take_left   (take_left),
        .left_entry  (left_entry),
        .right_entry (right_entry),
        .cur_entry   (cell_entry[gi]),
        .take        (cell_take[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt     = count_r;
    head_tag_nxt  = '0;
    head_prio_nxt = '0;
    status_nxt    = ST_OK;
    case (kind)
      KIND_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      KIND_REMOVE, KIND_PEEK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          head_tag_nxt  = cell_entry[0].tag;
          head_prio_nxt = cell_entry[0].prio;
          if (kind == KIND_REMOVE) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Occupancy is reported modulo 256.
  assign occ_ext = {{OCC_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the result while the downstream side stalls.
  always_ff @(posedge clk) begin
    if (accept) begin
      head_tag_r  <= head_tag_nxt;
      head_prio_r <= head_prio_nxt;
      status_r    <= status_nxt;
      occ_r       <= occ_ext[OCC_W-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_head_tag  = head_tag_r;
  assign out_head_prio = head_prio_r;
  assign out_status    = status_r;
  assign out_occupancy = occ_r;

endmodule

`default_nettype wire

// ----- tb/sorted_array_priority_queue_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for sorted_array_priority_queue: directed table,
// then random fill/drain traffic.
// Depends on spq_pkg and the sorted_array_priority_queue RTL; a shadow queue predicts every untyped result.

module sorted_array_priority_queue_tb;
  import spq_pkg::*;

  localparam int DEPTH           = DEPTH_DEF;
  localparam int DIRECTED_ROWS   = 24;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int QUIET_LIMIT     = 2000;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
    status_t           status;
    logic [OCC_W-1:0]  occ;
  } head_result_t;

  typedef struct {
    kind_t             kind;
    logic [TAG_W-1:0]  tag;
    logic [PRIO_W-1:0] prio;
    bit                typed;
    head_result_t      want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [KIND_W-1:0]   in_kind = '0;
  logic [TAG_W-1:0]    in_tag = '0;
  logic [PRIO_W-1:0]   in_prio = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [TAG_W-1:0]    out_head_tag;
  logic [PRIO_W-1:0]   out_head_prio;
  logic [STATUS_W-1:0] out_status;
  logic [OCC_W-1:0]    out_occupancy;

  // shadow copy of the queue contents
  logic [TAG_W-1:0]  shadow_tag [DEPTH];
  logic [PRIO_W-1:0] shadow_prio [DEPTH];
  int unsigned       shadow_count;

  head_result_t due_heads [$];
  head_result_t oldest_due;

  int unsigned send_idle_pct = 15;
  int unsigned recv_stall_pct = 61;
  int unsigned mismatches = 0;
  int unsigned ops_sent = 0;
  int unsigned results_seen = 0;
  int unsigned full_drops = 0;
  int unsigned empty_hits = 0;
  int unsigned capacity_hits = 0;
  int unsigned quiet_cycles = 0;

  // Extremes, ties and empty-queue cases; typed rows follow directly from the queue rules.
  stim_row_t directed [DIRECTED_ROWS] = '{
    '{KIND_REMOVE, 32'h0,        16'h0,    1'b1, '{32'h0, 16'h0, ST_EMPTY, 8'd0}},
    '{KIND_PEEK,   32'h0,        16'h0,    1'b1, '{32'h0, 16'h0, ST_EMPTY, 8'd0}},
    '{KIND_NOP,    32'hFFFFFFFF, 16'hFFFF, 1'b1, '{32'h0, 16'h0, ST_OK,    8'd0}},
    '{KIND_INSERT, 32'hFFFFFFFF, 16'hFFFF, 1'b1, '{32'h0, 16'h0, ST_OK,    8'd1}},
    '{KIND_INSERT, 32'h0,        16'h0,    1'b1, '{32'h0, 16'h0, ST_OK,    8'd2}},
    '{KIND_PEEK,   32'h12345678, 16'hABCD, 1'b1, '{32'h0, 16'h0, ST_OK,    8'd2}},
    '{KIND_INSERT, 32'h1,        16'd100,  1'b0, '0},
    '{KIND_INSERT, 32'h2,        16'd100,  1'b0, '0},
    '{KIND_INSERT, 32'h3,        16'd50,   1'b0, '0},
    '{KIND_INSERT, 32'h4,        16'd100,  1'b0, '0},
    '{KIND_NOP,    32'hDEADBEEF, 16'h0001, 1'b0, '0},
    '{KIND_REMOVE, 32'hFFFFFFFF, 16'hFFFF, 1'b0, '0},
    '{KIND_REMOVE, 32'h0,        16'h0,    1'b0, '0},
    '{KIND_PEEK,   32'h0,        16'h0,    1'b0, '0},
    '{KIND_REMOVE, 32'h0,        16'h0,    1'b0, '0},
    '{KIND_REMOVE, 32'h0,        16'h0,    1'b0, '0},
    '{KIND_INSERT, 32'hAAAAAAAA, 16'h0,    1'b0, '0},
    '{KIND_INSERT, 32'h55555555, 16'h8000, 1'b0, '0},
    '{KIND_REMOVE, 32'h0,        16'h0,    1'b0, '0},
    '{KIND_REMOVE, 32'h0,        16'h0,    1'b0, '0},
    '{KIND_REMOVE, 32'h0,        16'h0,    1'b0, '0},
    '{KIND_REMOVE, 32'h0,        16'h0,    1'b0, '0},
    '{KIND_REMOVE, 32'h0,        16'h0,    1'b1, '{32'h0, 16'h0, ST_EMPTY, 8'd0}},
    '{KIND_PEEK,   32'h0,        16'h0,    1'b1, '{32'h0, 16'h0, ST_EMPTY, 8'd0}}
  };

  sorted_array_priority_queue #(.DEPTH(DEPTH)) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_tag        (in_tag),
    .in_prio       (in_prio),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_head_tag  (out_head_tag),
    .out_head_prio (out_head_prio),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

  always #10 clk = ~clk;

  // Apply one operation to the shadow queue and return the head result it gives.
  function automatic head_result_t apply_queue_op(kind_t kind, logic [TAG_W-1:0] tag,
                                                  logic [PRIO_W-1:0] prio);
    head_result_t res;
    int unsigned  pos;
    res = '0;
    res.status = ST_OK;
    if (kind == KIND_INSERT) begin
      if (shadow_count >= DEPTH) begin
        res.status = ST_FULL;
        full_drops++;
      end else begin
        // new entry goes behind every entry of equal or smaller priority
        pos = shadow_count;
        while (pos > 0 && prio < shadow_prio[pos-1]) begin
          shadow_tag[pos]  = shadow_tag[pos-1];
          shadow_prio[pos] = shadow_prio[pos-1];
          pos--;
        end
        shadow_tag[pos]  = tag;
        shadow_prio[pos] = prio;
        shadow_count++;
        if (shadow_count == DEPTH) capacity_hits++;
      end
    end else if (kind == KIND_REMOVE || kind == KIND_PEEK) begin
      if (shadow_count == 0) begin
        res.status = ST_EMPTY;
        empty_hits++;
      end else begin
        res.tag  = shadow_tag[0];
        res.prio = shadow_prio[0];
        if (kind == KIND_REMOVE) begin
          for (int i = 0; i + 1 < shadow_count; i++) begin
            shadow_tag[i]  = shadow_tag[i+1];
            shadow_prio[i] = shadow_prio[i+1];
          end
          shadow_count--;
          shadow_tag[shadow_count]  = '0;
          shadow_prio[shadow_count] = '0;
        end
      end
    end
    res.occ = shadow_count[OCC_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [TAG_W-1:0] got, logic [TAG_W-1:0] want);
    $display("MISMATCH result %0d %s: got %h expected %h", results_seen, what, got, want);
    mismatches++;
  endtask

  // Drive one transaction, hold it until accepted, then log its expected head.
  task automatic send_op(kind_t kind, logic [TAG_W-1:0] tag, logic [PRIO_W-1:0] prio,
                         bit typed, head_result_t want);
    head_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_tag   <= tag;
    in_prio  <= prio;
    do @(posedge clk); while (in_stall);
    predicted = apply_queue_op(kind, tag, prio);
    due_heads.push_back(typed ? want : predicted);
    ops_sent++;
  endtask

  // Hold off the sender until every pending result has drained.
  task automatic drain_pending();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_heads.size() != 0);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_heads.size() == 0) begin
        report_mismatch("unexpected result", out_head_tag, '0);
      end else begin
        oldest_due = due_heads.pop_front();
        if (out_head_tag !== oldest_due.tag)
          report_mismatch("head_tag", out_head_tag, oldest_due.tag);
        if (out_head_prio !== oldest_due.prio)
          report_mismatch("head_prio", TAG_W'(out_head_prio), TAG_W'(oldest_due.prio));
        if (out_status !== oldest_due.status)
          report_mismatch("status", TAG_W'(out_status), TAG_W'(oldest_due.status));
        if (out_occupancy !== oldest_due.occ)
          report_mismatch("occupancy", TAG_W'(out_occupancy), TAG_W'(oldest_due.occ));
      end
      results_seen++;
    end
  end

  // Watchdog: end the run if no transaction moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    bit                filling;
    int unsigned       roll;
    int unsigned       counted;
    kind_t             kind;
    logic [PRIO_W-1:0] prio;

    filling = 1'b1;
    for (int i = 0; i < DEPTH; i++) begin
      shadow_tag[i]  = '0;
      shadow_prio[i] = '0;
    end
    shadow_count = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++)
      send_op(directed[r].kind, directed[r].tag, directed[r].prio,
              directed[r].typed, directed[r].want);

    for (int phase = 0; phase < 3; phase++) begin
      drain_pending();
      case (phase)
        0: begin
          send_idle_pct  = 15;
          recv_stall_pct = 61;
        end
        1: begin
          send_idle_pct  = 61;
          recv_stall_pct = 15;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        // fill toward capacity, then drain toward empty, with a little noise
        roll = $urandom_range(99);
        if (filling)
          kind = roll < 88 ? KIND_INSERT : roll < 94 ? KIND_REMOVE :
                 roll < 98 ? KIND_PEEK : KIND_NOP;
        else
          kind = roll < 84 ? KIND_REMOVE : roll < 90 ? KIND_INSERT :
                 roll < 98 ? KIND_PEEK : KIND_NOP;
        roll = $urandom_range(9);
        if (roll < 4)
          prio = PRIO_W'($urandom_range(7));
        else if (roll == 4)
          prio = $urandom_range(1) ? '1 : '0;
        else
          prio = PRIO_W'($urandom_range(16'hFFFF));
        send_op(kind, $urandom, prio, 1'b0, '0);
        if (kind != KIND_NOP) counted++;
        if (filling && shadow_count == DEPTH && $urandom_range(3) == 0) filling = 1'b0;
        else if (!filling && shadow_count == 0 && $urandom_range(3) == 0) filling = 1'b1;
      end
    end

    drain_pending();
    repeat (4) @(posedge clk);

    $display("Covered %0d operations, %0d results checked; queue reached capacity %0d times,",
             ops_sent, results_seen, capacity_hits);
    $display("with %0d dropped inserts and %0d remove/peek on empty queue.",
             full_drops, empty_hits);
    if (mismatches == 0 && due_heads.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
